@@ hw/rtl/dnsv_pkg.sv @@
// Shared types, phase codes and constants for the DNS message validator.
package dnsv_pkg;

	localparam int DNSV_OFFSET_WIDTH = 16;

	localparam int HDR_SIZE  = 12;
	localparam logic [1:0] PTR_MARK = 2'b11;
	localparam logic [7:0] LABEL_MAX = 8'd63;
	localparam logic [8:0] NAME_MAX  = 9'd253;
	localparam logic [7:0] CHR_LOW   = 8'h20;
	localparam logic [7:0] CHR_HIGH  = 8'h7E;
	localparam logic [15:0] RR_FIXED = 16'd8;
	localparam logic [15:0] Q_FIXED  = 16'd4;

	localparam logic [3:0] PH_HEADER  = 4'd0;
	localparam logic [3:0] PH_Q_LEN   = 4'd1;
	localparam logic [3:0] PH_Q_CHR   = 4'd2;
	localparam logic [3:0] PH_Q_FIX   = 4'd3;
	localparam logic [3:0] PH_R_FIRST = 4'd4;
	localparam logic [3:0] PH_R_LEN   = 4'd5;
	localparam logic [3:0] PH_R_CHR   = 4'd6;
	localparam logic [3:0] PH_R_PTR   = 4'd7;
	localparam logic [3:0] PH_R_FIX   = 4'd8;
	localparam logic [3:0] PH_R_RDH   = 4'd9;
	localparam logic [3:0] PH_R_RDL   = 4'd10;
	localparam logic [3:0] PH_R_RDATA = 4'd11;
	localparam logic [3:0] PH_DONE    = 4'd12;

	typedef struct packed {
		logic [7:0] msg_byte;
		logic       last_byte;
	} in_t;

	typedef struct packed {
		logic        msg_ok;
		logic [15:0] questions_end;
		logic [15:0] answers_end;
		logic [15:0] authority_end;
		logic [15:0] additional_end;
	} out_t;

	typedef struct packed {
		logic push;
		out_t data;
	} res_push_t;

endpackage

@@ hw/rtl/dnsv_parser.sv @@
// Byte-at-a-time DNS message walker that emits one verdict per message.
module dnsv_parser import dnsv_pkg::*; #(
	parameter int OFFSET_WIDTH = DNSV_OFFSET_WIDTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  in_t       msg,
	output res_push_t res
);

	localparam int OW = OFFSET_WIDTH;
	localparam logic [OW-1:0] OFF_MAX = {OW{1'b1}};

	logic [OW-1:0] off_q, n_off;
	logic [15:0]   counts_q [4];
	logic [15:0]   n_counts [4];
	logic [3:0]    phase_q, n_phase;
	logic [15:0]   rec_q, n_rec;
	logic [5:0]    lab_q, n_lab;
	logic [8:0]    nlen_q, n_nlen;
	logic          root_q, n_root;
	logic [15:0]   skip_q, n_skip;
	logic [OW-1:0] ends_q [4];
	logic [OW-1:0] n_ends [4];
	logic          failed_q, n_failed;
	logic [1:0]    sec_q, n_sec;

	logic [7:0]    b;
	logic [OW-1:0] end_off;
	logic          do_finish, do_open, found, ok;
	logic [2:0]    open_from;
	logic [OW-1:0] open_end;
	logic [3:0]    hdr_sub;
	logic [8:0]    nl;
	logic [5:0]    lab_dec;
	logic [15:0]   skip_dec, rec_dec, rdlen;
	out_t          res_d;

	always_comb begin
		b = msg.msg_byte;
		end_off = off_q + OW'(1);
		n_off = off_q;
		n_counts = counts_q;
		n_phase = phase_q;
		n_rec = rec_q;
		n_lab = lab_q;
		n_nlen = nlen_q;
		n_root = root_q;
		n_skip = skip_q;
		n_ends = ends_q;
		n_failed = failed_q;
		n_sec = sec_q;
		do_finish = 1'b0;
		do_open = 1'b0;
		found = 1'b0;
		open_from = 3'd0;
		open_end = end_off;
		hdr_sub = off_q[3:0] - 4'd4;
		nl = nlen_q + {1'b0, b} + 9'd1;
		lab_dec = lab_q - 6'd1;
		skip_dec = skip_q - 16'd1;
		rec_dec = rec_q - 16'd1;
		rdlen = {skip_q[15:8], b};

		if (!failed_q && phase_q != PH_DONE) begin
			if (off_q == OFF_MAX) begin
				n_failed = 1'b1;
			end else begin
				case (phase_q)
					PH_HEADER: begin
						if (off_q >= OW'(4) && off_q < OW'(HDR_SIZE)) begin
							if (!off_q[0]) begin
								n_counts[hdr_sub[2:1]][15:8] = b;
							end else begin
								n_counts[hdr_sub[2:1]][7:0] = b;
							end
						end
						if (off_q == OW'(HDR_SIZE - 1)) begin
							do_open = 1'b1;
						end
					end
					PH_Q_LEN: begin
						if (b == 8'd0) begin
							if (nlen_q == 9'd0 && root_q) begin
								n_failed = 1'b1;
							end else begin
								if (nlen_q == 9'd0) begin
									n_root = 1'b1;
								end
								n_skip = Q_FIXED;
								n_phase = PH_Q_FIX;
							end
						end else if (b > LABEL_MAX) begin
							n_failed = 1'b1;
						end else begin
							n_nlen = nl;
							if (nl > NAME_MAX) begin
								n_failed = 1'b1;
							end else begin
								n_lab = b[5:0];
								n_phase = PH_Q_CHR;
							end
						end
					end
					PH_Q_CHR, PH_R_CHR: begin
						if (!(b > CHR_LOW && b <= CHR_HIGH)) begin
							n_failed = 1'b1;
						end else begin
							n_lab = lab_dec;
							if (lab_dec == 6'd0) begin
								n_phase = (phase_q == PH_Q_CHR) ? PH_Q_LEN : PH_R_LEN;
							end
						end
					end
					PH_Q_FIX: begin
						n_skip = skip_dec;
						if (skip_dec == 16'd0) begin
							do_finish = 1'b1;
						end
					end
					PH_R_FIRST, PH_R_LEN: begin
						if (phase_q == PH_R_FIRST && b[7:6] == PTR_MARK) begin
							n_phase = PH_R_PTR;
						end else if (b == 8'd0) begin
							n_skip = RR_FIXED;
							n_phase = PH_R_FIX;
						end else if (b > LABEL_MAX) begin
							n_failed = 1'b1;
						end else begin
							n_lab = b[5:0];
							n_phase = PH_R_CHR;
						end
					end
					PH_R_PTR: begin
						n_skip = RR_FIXED;
						n_phase = PH_R_FIX;
					end
					PH_R_FIX: begin
						n_skip = skip_dec;
						if (skip_dec == 16'd0) begin
							n_phase = PH_R_RDH;
						end
					end
					PH_R_RDH: begin
						n_skip = {b, 8'd0};
						n_phase = PH_R_RDL;
					end
					PH_R_RDL: begin
						n_skip = rdlen;
						if (rdlen == 16'd0) begin
							do_finish = 1'b1;
						end else begin
							n_phase = PH_R_RDATA;
						end
					end
					PH_R_RDATA: begin
						n_skip = skip_dec;
						if (skip_dec == 16'd0) begin
							do_finish = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
		end

		if (do_finish) begin
			n_rec = rec_dec;
			if (rec_dec == 16'd0) begin
				n_ends[sec_q] = end_off;
				do_open = 1'b1;
				open_from = {1'b0, sec_q} + 3'd1;
			end else begin
				n_nlen = 9'd0;
				n_phase = (sec_q == 2'd0) ? PH_Q_LEN : PH_R_FIRST;
			end
		end

		if (do_open) begin
			for (int s = 0; s < 4; s++) begin
				if (3'(s) >= open_from && !found) begin
					if (n_counts[s] != 16'd0) begin
						found = 1'b1;
						n_sec = 2'(s);
						n_rec = n_counts[s];
						n_nlen = 9'd0;
						n_phase = (s == 0) ? PH_Q_LEN : PH_R_FIRST;
					end else begin
						n_ends[s] = open_end;
					end
				end
			end
			if (!found) begin
				n_sec = 2'd3;
				n_phase = PH_DONE;
			end
		end

		if (off_q != OFF_MAX) begin
			n_off = end_off;
		end

		ok = !n_failed && n_phase == PH_DONE;
		res_d.msg_ok = ok;
		res_d.questions_end  = ok ? 16'(n_ends[0]) : 16'd0;
		res_d.answers_end    = ok ? 16'(n_ends[1]) : 16'd0;
		res_d.authority_end  = ok ? 16'(n_ends[2]) : 16'd0;
		res_d.additional_end = ok ? 16'(n_ends[3]) : 16'd0;
		res.push = fire && msg.last_byte;
		res.data = res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= '0;
			phase_q <= PH_HEADER;
			rec_q <= '0;
			lab_q <= '0;
			nlen_q <= '0;
			root_q <= 1'b0;
			skip_q <= '0;
			failed_q <= 1'b0;
			sec_q <= '0;
			for (int i = 0; i < 4; i++) begin
				counts_q[i] <= '0;
				ends_q[i] <= '0;
			end
		end else if (fire) begin
			if (msg.last_byte) begin
				off_q <= '0;
				phase_q <= PH_HEADER;
				rec_q <= '0;
				lab_q <= '0;
				nlen_q <= '0;
				root_q <= 1'b0;
				skip_q <= '0;
				failed_q <= 1'b0;
				sec_q <= '0;
				for (int i = 0; i < 4; i++) begin
					counts_q[i] <= '0;
					ends_q[i] <= '0;
				end
			end else begin
				off_q <= n_off;
				phase_q <= n_phase;
				rec_q <= n_rec;
				lab_q <= n_lab;
				nlen_q <= n_nlen;
				root_q <= n_root;
				skip_q <= n_skip;
				failed_q <= n_failed;
				sec_q <= n_sec;
				counts_q <= n_counts;
				ends_q <= n_ends;
			end
		end
	end

	// A failure freezes the phase, so a finished walk can never be marked failed.
	a_done_not_failed: assert property (@(posedge clk) disable iff (!arst_n)
		!(phase_q == PH_DONE && failed_q))
		else $error("parser reached the done phase with the failure flag set");

	a_label_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_Q_CHR || phase_q == PH_R_CHR) |-> lab_q != 6'd0)
		else $error("label byte phase entered with no label bytes left");

	a_name_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(nlen_q > NAME_MAX) |-> failed_q)
		else $error("question name exceeded its limit without a failure");

	a_rec_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_HEADER && phase_q != PH_DONE && !failed_q) |-> rec_q != 16'd0)
		else $error("section walk active with no items left");

endmodule

@@ hw/rtl/dns_message_validator.sv @@
// Top level of the DNS message validator: byte parser and a two-entry result buffer.
//
// The block takes a DNS message on the msg channel, one byte per transfer,
// header first, with last_byte set on the final byte. A transfer happens on a
// rising clock edge where msg_valid and msg_ready are both high.
// Each message yields exactly one result on the res channel: msg_ok and the
// byte offsets at which the question, answer, authority and additional
// sections end (all zero when msg_ok is low).
// Throughput is one byte per cycle while msg_ready is high; the parser updates its walk state from
// each byte in the cycle the byte is transferred.
// The result appears on res the cycle after the last byte of its message is
// transferred, if the buffer ahead of it is empty.
// Results wait in a two-entry buffer. While one result is stalled by a low
// res_ready, bytes keep flowing; msg_ready drops only when both entries are
// full, and rises again as soon as the receiver takes a result.
// Reset clears the walk state and empties the result buffer; the first byte
// after reset is taken as the first header byte of a message.
module dns_message_validator import dnsv_pkg::*; #(
	parameter int OFFSET_WIDTH = DNSV_OFFSET_WIDTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic msg_valid,
	output logic msg_ready,
	input  in_t  msg,
	output logic res_valid,
	input  logic res_ready,
	output out_t res
);

	res_push_t push;
	logic      fire, pop;
	logic      main_v_q, skid_v_q;
	out_t      main_q, skid_q;

	assign msg_ready = !skid_v_q;
	assign fire = msg_valid && msg_ready;
	assign pop = main_v_q && res_ready;
	assign res_valid = main_v_q;
	assign res = main_q;

	dnsv_parser #(
		.OFFSET_WIDTH(OFFSET_WIDTH)
	) u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.fire(fire),
		.msg(msg),
		.res(push)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else begin
				main_v_q <= push.push;
			end
		end else if (push.push) begin
			if (!main_v_q) begin
				main_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_v_q) begin
				main_q <= skid_q;
			end else if (push.push) begin
				main_q <= push.data;
			end
		end else if (push.push) begin
			if (!main_v_q) begin
				main_q <= push.data;
			end else begin
				skid_q <= push.data;
			end
		end
	end

	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> main_v_q)
		else $error("skid entry holds a result while the output entry is empty");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && skid_v_q) |=> (main_v_q && !skid_v_q))
		else $error("skid entry did not move into the output entry");

	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(push.push && !main_v_q) |=> (main_v_q && !skid_v_q))
		else $error("result into an empty buffer did not reach the output entry");

endmodule

@@ dv/dns_verdict_pkg.sv @@
// Verdict predictor and result checker for the DNS message validator testbench.
package dns_verdict_pkg;
	import dnsv_pkg::*;

	localparam int POS_LIMIT = (1 << DNSV_OFFSET_WIDTH) - 1;

	class verdict_board;
		int          pos;
		logic [15:0] hdr_count[4];
		logic [3:0]  stage;
		logic [15:0] items_left;
		logic [5:0]  label_rem;
		logic [8:0]  qname_len;
		logic        root_seen;
		logic [16:0] skip_cnt;
		logic [15:0] sect_end[4];
		logic        bad;
		logic [1:0]  sect_idx;
		out_t        pending_verdicts[$];
		int          bytes_taken;
		int          msgs_checked;
		int          msgs_ok;
		int          errors;

		function new();
			restart();
			bytes_taken = 0;
			msgs_checked = 0;
			msgs_ok = 0;
			errors = 0;
		endfunction

		function void restart();
			pos = 0;
			foreach (hdr_count[i]) begin
				hdr_count[i] = '0;
				sect_end[i] = '0;
			end
			stage = PH_HEADER;
			items_left = '0;
			label_rem = '0;
			qname_len = '0;
			root_seen = 1'b0;
			skip_cnt = '0;
			bad = 1'b0;
			sect_idx = '0;
		endfunction

		// Empty sections end where the previous one ended.
		function void open_from(int from, logic [15:0] endv);
			for (int s = from; s < 4; s++) begin
				if (hdr_count[s] != 0) begin
					sect_idx = 2'(s);
					items_left = hdr_count[s];
					qname_len = '0;
					stage = (s == 0) ? PH_Q_LEN : PH_R_FIRST;
					return;
				end
				sect_end[s] = endv;
			end
			sect_idx = 2'd3;
			stage = PH_DONE;
		endfunction

		function void close_item(logic [15:0] endv);
			items_left = items_left - 16'd1;
			if (items_left == 0) begin
				sect_end[sect_idx] = endv;
				open_from(int'(sect_idx) + 1, endv);
			end else begin
				qname_len = '0;
				stage = (sect_idx == 0) ? PH_Q_LEN : PH_R_FIRST;
			end
		endfunction

		function void rec_len(logic [7:0] b);
			if (b == 0) begin
				skip_cnt = 17'(RR_FIXED);
				stage = PH_R_FIX;
			end else if (b > LABEL_MAX) begin
				bad = 1'b1;
			end else begin
				label_rem = b[5:0];
				stage = PH_R_CHR;
			end
		endfunction

		function void walk(logic [7:0] b, int p);
			logic [15:0] endv;
			int k;
			endv = 16'(p + 1);
			case (stage)
			PH_HEADER: begin
				if (p >= 4 && p < HDR_SIZE) begin
					k = (p - 4) / 2;
					if ((p - 4) % 2 == 0)
						hdr_count[k][15:8] = b;
					else
						hdr_count[k][7:0] = b;
				end
				if (endv == HDR_SIZE)
					open_from(0, endv);
			end
			PH_Q_LEN: begin
				if (b == 0) begin
					if (qname_len == 0) begin
						if (root_seen) begin
							bad = 1'b1;
							return;
						end
						root_seen = 1'b1;
					end
					skip_cnt = 17'(Q_FIXED);
					stage = PH_Q_FIX;
				end else if (b > LABEL_MAX) begin
					bad = 1'b1;
				end else begin
					qname_len = 9'(qname_len + b + 1);
					if (qname_len > NAME_MAX) begin
						bad = 1'b1;
						return;
					end
					label_rem = b[5:0];
					stage = PH_Q_CHR;
				end
			end
			PH_Q_CHR, PH_R_CHR: begin
				if (b <= CHR_LOW || b > CHR_HIGH) begin
					bad = 1'b1;
					return;
				end
				label_rem = label_rem - 6'd1;
				if (label_rem == 0)
					stage = (stage == PH_Q_CHR) ? PH_Q_LEN : PH_R_LEN;
			end
			PH_Q_FIX: begin
				skip_cnt = skip_cnt - 17'd1;
				if (skip_cnt == 0)
					close_item(endv);
			end
			PH_R_FIRST: begin
				if (b[7:6] == PTR_MARK)
					stage = PH_R_PTR;
				else
					rec_len(b);
			end
			PH_R_LEN: rec_len(b);
			PH_R_PTR: begin
				skip_cnt = 17'(RR_FIXED);
				stage = PH_R_FIX;
			end
			PH_R_FIX: begin
				skip_cnt = skip_cnt - 17'd1;
				if (skip_cnt == 0)
					stage = PH_R_RDH;
			end
			PH_R_RDH: begin
				skip_cnt = {1'b0, b, 8'h00};
				stage = PH_R_RDL;
			end
			PH_R_RDL: begin
				skip_cnt = skip_cnt | 17'(b);
				if (skip_cnt == 0)
					close_item(endv);
				else
					stage = PH_R_RDATA;
			end
			PH_R_RDATA: begin
				skip_cnt = skip_cnt - 17'd1;
				if (skip_cnt == 0)
					close_item(endv);
			end
			default: ;
			endcase
		endfunction

		function void take_byte(in_t it);
			out_t v;
			if (!bad && stage != PH_DONE) begin
				if (pos >= POS_LIMIT)
					bad = 1'b1;
				else
					walk(it.msg_byte, pos);
			end
			if (pos < POS_LIMIT)
				pos++;
			bytes_taken++;
			if (it.last_byte) begin
				v = '0;
				if (!bad && stage == PH_DONE) begin
					v.msg_ok = 1'b1;
					v.questions_end = sect_end[0];
					v.answers_end = sect_end[1];
					v.authority_end = sect_end[2];
					v.additional_end = sect_end[3];
				end
				pending_verdicts.push_back(v);
				restart();
			end
		endfunction

		function void same_field(string name, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void match_verdict(out_t got);
			out_t want;
			msgs_checked++;
			if (pending_verdicts.size() == 0) begin
				$error("Result transfer with no message pending");
				errors++;
				return;
			end
			want = pending_verdicts.pop_front();
			if (want.msg_ok)
				msgs_ok++;
			same_field("msg_ok", 16'(want.msg_ok), 16'(got.msg_ok));
			same_field("questions_end", want.questions_end, got.questions_end);
			same_field("answers_end", want.answers_end, got.answers_end);
			same_field("authority_end", want.authority_end, got.authority_end);
			same_field("additional_end", want.additional_end, got.additional_end);
		endfunction
	endclass

endpackage

@@ dv/tb_dns_message_validator.sv @@
// Top-level testbench for the DNS message validator.
module tb_dns_message_validator;
	timeunit 1ns;
	timeprecision 1ps;

	import dnsv_pkg::*;
	import dns_verdict_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int HOLD_CYCLES = 600;
	localparam int HOLD_AFTER = 25;
	localparam int RANDOM_BYTES = 450;
	localparam int RANDOM_MSGS = 60;
	localparam int DRAIN_CYCLES = 20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic msg_valid = 1'b0;
	logic msg_ready;
	in_t  msg = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	out_t res;

	verdict_board board = new();
	logic [7:0] msg_bytes[$];
	int burst_left = 0;
	int cycles = 0;
	int in_stall_cycles = 0;

	dns_message_validator DUT (
		.clk(clk),
		.arst_n(arst_n),
		.msg_valid(msg_valid),
		.msg_ready(msg_ready),
		.msg(msg),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (msg_valid && msg_ready)
			board.take_byte(msg);
		if (msg_valid && !msg_ready)
			in_stall_cycles++;
		if (res_valid && res_ready)
			board.match_verdict(res);
	end

	initial begin : result_side
		int seg_left;
		int mode;
		int hold_left;
		bit held;
		bit r;
		seg_left = 0;
		mode = 0;
		hold_left = 0;
		held = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				r = 1'b0;
			end else if (!held && board.msgs_checked >= HOLD_AFTER) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
				r = 1'b0;
			end else begin
				if (seg_left == 0) begin
					mode = $urandom_range(0, 3);
					seg_left = $urandom_range(20, 80);
				end
				seg_left--;
				case (mode)
				0: r = 1'b1;
				1: r = 1'($urandom_range(0, 1));
				2: r = ($urandom_range(0, 3) == 0);
				default: r = ($urandom_range(0, 9) != 0);
				endcase
			end
			res_ready <= r;
		end
	end

	function automatic void put_counts(int qd, int an, int ns, int ar);
		int c[4] = '{qd, an, ns, ar};
		repeat (4) msg_bytes.push_back(8'($urandom));
		foreach (c[i]) begin
			msg_bytes.push_back(8'(c[i] >> 8));
			msg_bytes.push_back(8'(c[i]));
		end
	endfunction

	function automatic void put_label(int len);
		msg_bytes.push_back(8'(len));
		repeat (len) msg_bytes.push_back(8'($urandom_range(CHR_HIGH, CHR_LOW + 1)));
	endfunction

	function automatic void put_qtail();
		msg_bytes.push_back(8'h00);
		repeat (Q_FIXED) msg_bytes.push_back(8'($urandom));
	endfunction

	function automatic void put_question(bit root);
		int n;
		if (!root) begin
			n = $urandom_range(1, 3);
			repeat (n) put_label(($urandom_range(0, 19) == 0) ? LABEL_MAX : $urandom_range(1, 8));
		end
		put_qtail();
	endfunction

	function automatic void put_pointer();
		msg_bytes.push_back({PTR_MARK, 6'($urandom)});
		msg_bytes.push_back(8'($urandom));
	endfunction

	function automatic void put_rr_tail(int rdlen);
		repeat (RR_FIXED) msg_bytes.push_back(8'($urandom));
		msg_bytes.push_back(8'(rdlen >> 8));
		msg_bytes.push_back(8'(rdlen));
		repeat (rdlen) msg_bytes.push_back(8'($urandom));
	endfunction

	function automatic void put_record();
		if ($urandom_range(0, 1) == 0) begin
			put_pointer();
		end else begin
			repeat ($urandom_range(0, 2)) put_label($urandom_range(1, 10));
			msg_bytes.push_back(8'h00);
		end
		put_rr_tail(($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6));
	endfunction

	function automatic void put_random_msg();
		int kind;
		int qd;
		int an;
		int ns;
		int ar;
		int cut;
		kind = $urandom_range(0, 99);
		if (kind < 8) begin
			repeat ($urandom_range(1, 40)) msg_bytes.push_back(8'($urandom));
			return;
		end
		qd = $urandom_range(0, 3);
		an = $urandom_range(0, 3);
		ns = $urandom_range(0, 2);
		ar = $urandom_range(0, 3);
		put_counts(qd, an, ns, ar);
		repeat (qd) put_question($urandom_range(0, 7) == 0);
		repeat (an + ns + ar) put_record();
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 5)) msg_bytes.push_back(8'($urandom));
		if (kind < 28) begin
			cut = $urandom_range(1, msg_bytes.size() - 1);
			while (msg_bytes.size() > cut)
				void'(msg_bytes.pop_back());
		end else if (kind < 40) begin
			msg_bytes[$urandom_range(0, msg_bytes.size() - 1)] = 8'($urandom);
		end
	endfunction

	task automatic send_msg(bit steady);
		for (int i = 0; i < msg_bytes.size(); i++) begin
			if (!steady && burst_left == 0) begin
				msg_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
				burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
					: $urandom_range(1, 24);
			end
			msg_valid <= 1'b1;
			msg <= '{msg_byte: msg_bytes[i], last_byte: (i == msg_bytes.size() - 1)};
			do @(posedge clk); while (!msg_ready);
			@(negedge clk);
			if (burst_left > 0)
				burst_left--;
		end
		msg_bytes.delete();
	endtask

	task automatic directed_msgs();
		msg_bytes.push_back(8'($urandom));
		send_msg(1'b0);
		repeat (HDR_SIZE - 1) msg_bytes.push_back(8'($urandom));
		send_msg(1'b0);
		put_counts(0, 0, 0, 0);
		send_msg(1'b0);
		put_counts(1, 0, 0, 0);
		send_msg(1'b0);

		put_counts(1, 1, 0, 1);
		msg_bytes.push_back(8'd2);
		msg_bytes.push_back(CHR_LOW + 8'd1);
		msg_bytes.push_back(CHR_HIGH);
		put_qtail();
		put_pointer();
		put_rr_tail(0);
		put_label(5);
		msg_bytes.push_back(8'h00);
		put_rr_tail(3);
		repeat (3) msg_bytes.push_back(8'($urandom));
		send_msg(1'b0);

		put_counts(1, 0, 0, 0);
		repeat (3) put_label(LABEL_MAX);
		put_label(60);
		put_qtail();
		send_msg(1'b0);
		put_counts(1, 0, 0, 0);
		repeat (3) put_label(LABEL_MAX);
		put_label(61);
		put_qtail();
		send_msg(1'b0);

		put_counts(1, 0, 0, 0);
		msg_bytes.push_back(LABEL_MAX + 8'd1);
		repeat (8) msg_bytes.push_back(8'h61);
		send_msg(1'b0);
		put_counts(0, 0, 1, 0);
		msg_bytes.push_back(LABEL_MAX + 8'd1);
		put_rr_tail(0);
		send_msg(1'b0);
		put_counts(0, 0, 0, 1);
		msg_bytes.push_back(8'h80);
		msg_bytes.push_back(8'h00);
		put_rr_tail(0);
		send_msg(1'b0);

		put_counts(1, 0, 0, 0);
		msg_bytes.push_back(8'd3);
		msg_bytes.push_back(8'h61);
		msg_bytes.push_back(CHR_LOW);
		msg_bytes.push_back(8'h61);
		put_qtail();
		send_msg(1'b0);
		put_counts(0, 1, 0, 0);
		msg_bytes.push_back(8'd2);
		msg_bytes.push_back(8'h61);
		msg_bytes.push_back(CHR_HIGH + 8'd1);
		msg_bytes.push_back(8'h00);
		put_rr_tail(0);
		send_msg(1'b0);

		put_counts(2, 0, 0, 0);
		put_question(1'b1);
		put_question(1'b0);
		send_msg(1'b0);
		put_counts(2, 0, 0, 0);
		put_question(1'b0);
		put_question(1'b1);
		send_msg(1'b0);
		put_counts(3, 0, 0, 0);
		put_question(1'b1);
		put_question(1'b0);
		put_question(1'b1);
		send_msg(1'b0);

		put_counts(0, 1, 0, 0);
		put_pointer();
		put_rr_tail(257);
		send_msg(1'b0);
		put_counts(0, 1, 0, 0);
		put_pointer();
		put_rr_tail(20);
		repeat (10) void'(msg_bytes.pop_back());
		send_msg(1'b0);
		put_counts(0, 0, 0, 16'hFFFF);
		put_record();
		send_msg(1'b0);

		// The first message's sections end exactly at the top offset; the second needs one byte more.
		put_counts(0, 1, 0, 0);
		put_pointer();
		put_rr_tail(POS_LIMIT - 24);
		msg_bytes.push_back(8'($urandom));
		send_msg(1'b1);
		put_counts(0, 1, 0, 0);
		put_pointer();
		put_rr_tail(POS_LIMIT - 23);
		send_msg(1'b1);
	endtask

	initial begin : stimulus
		int rnd_bytes;
		int rnd_msgs;
		rnd_bytes = 0;
		rnd_msgs = 0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		directed_msgs();
		while (rnd_bytes < RANDOM_BYTES || rnd_msgs < RANDOM_MSGS) begin
			put_random_msg();
			rnd_bytes += msg_bytes.size();
			rnd_msgs++;
			send_msg(1'b0);
		end
		msg_valid <= 1'b0;
		while (board.pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Checked %0d messages, %0d expected to pass, from %0d bytes.",
			board.msgs_checked, board.msgs_ok, board.bytes_taken);
		$display("Input was held off for %0d cycles while the result side stalled.",
			in_stall_cycles);
		if (board.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/dnsv_pkg.sv
hw/rtl/dnsv_parser.sv
hw/rtl/dns_message_validator.sv
dv/dns_verdict_pkg.sv
dv/tb_dns_message_validator.sv
